// ----- hdl/ssd_pkg.sv -----
// Shared types, codes and the glyph font for the seven-segment scan driver.
// No dependencies; every other file of the block imports this package.
package ssd_pkg;

    localparam int DIGIT_COUNT_DEFAULT = 8;
    localparam int SLOT_COUNT          = 8;
    localparam int POS_W               = 3;
    localparam int CODE_W              = 6;
    localparam int SEG_W               = 8;
    localparam int FONT_SIZE           = 43;

    localparam logic [CODE_W-1:0] BLANK_CODE = 6'd16;

    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [CODE_W-1:0] t_code;
    typedef logic [SEG_W-1:0]  t_seg;

    // Command codes carried in the one-bit command field.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Active-high font: segments a..g in bits 0..6, decimal point in bit 7.
    localparam t_seg FONT [FONT_SIZE] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71,
        8'h00, 8'h40, 8'h76, 8'h1E, 8'h70, 8'h38, 8'h37, 8'h5C,
        8'h73, 8'h3E, 8'h78, 8'h3D, 8'h67, 8'h50, 8'h37, 8'h6E,
        8'hBF, 8'h86, 8'hDB, 8'hCF, 8'hE6, 8'hED, 8'hFD, 8'h87,
        8'hFF, 8'hEF, 8'h46
    };

    // Codes past the end of the font show nothing.
    function automatic t_seg glyph_pattern(input t_code code);
        t_seg pat;
        pat = '0;
        if (code < CODE_W'(FONT_SIZE)) begin
            pat = FONT[code];
        end
        return pat;
    endfunction

endpackage

// ----- hdl/ssd_in_if.sv -----
// Request channel into the scan driver: valid/ready plus one command item.
// Depends on ssd_pkg for the field types.
interface ssd_in_if import ssd_pkg::*;;
    logic  valid;
    logic  ready;
    logic  command;
    t_pos  digit_position;
    t_code glyph_code;

    modport source (output valid, command, digit_position, glyph_code, input ready);
    modport sink   (input valid, command, digit_position, glyph_code, output ready);
endinterface

// ----- hdl/ssd_out_if.sv -----
// Result channel out of the scan driver: valid/ready plus segment and digit drive.
// Depends on ssd_pkg for the field types.
interface ssd_out_if import ssd_pkg::*;;
    logic valid;
    logic ready;
    t_seg segment_drive;
    t_seg digit_select;

    modport source (output valid, segment_drive, digit_select, input ready);
    modport sink   (input valid, segment_drive, digit_select, output ready);
endinterface

// ----- hdl/ssd_render.sv -----
// Turns a glyph code and a scan position into active-low display drive.
// Depends on ssd_pkg for the font and types.
module ssd_render import ssd_pkg::*; (
    input  t_code i_code,
    input  t_pos  i_pos,
    output t_seg  o_segment_drive,
    output t_seg  o_digit_select
);

    assign o_segment_drive = ~glyph_pattern(i_code);
    // Position 0 drives the top bit low.
    assign o_digit_select  = ~(t_seg'(8'h80) >> i_pos);

endmodule

// ----- hdl/seven_segment_scan_driver_core.sv -----
// A tick request passes through the request register, then the result register,
// before its result is shown; writes give no result.
// Throughput: one request per cycle; a held result stalls a tick in the request
// register, and with it every request behind that tick.
// Reset (synchronous, active low): all eight digit slots hold the blank code,
// the scan position returns to zero and both pipeline registers empty.
module seven_segment_scan_driver_core import ssd_pkg::*; #(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssd_in_if.sink    i_in,
    ssd_out_if.source o_out
);

    // Request register: the accepted item waits here until it can leave.
    logic  r_s1_valid;
    logic  r_s1_cmd;
    t_pos  r_s1_pos;
    t_code r_s1_code;

    // Architectural state: the digit store and the scan position.
    t_code r_store [SLOT_COUNT];
    t_pos  r_scan_pos;
    t_pos  n_scan_pos;

    // Result register.
    logic r_out_valid;
    t_seg r_seg;
    t_seg r_sel;

    logic s1_is_write;
    logic s1_adv;
    logic [POS_W:0] scan_inc;
    t_seg seg_drive;
    t_seg dig_select;

    // A write leaves the request register freely; a tick needs room in the
    // result register, which frees up when the downstream side takes it.
    assign s1_is_write = (r_s1_cmd == CMD_WRITE);
    assign s1_adv      = r_s1_valid && (s1_is_write || !r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_adv;

    // The scan wraps to zero once it reaches the configured digit count.
    assign scan_inc   = {1'b0, r_scan_pos} + (POS_W+1)'(1);
    assign n_scan_pos = (scan_inc >= (POS_W+1)'(DIGIT_COUNT)) ? '0 : scan_inc[POS_W-1:0];

    ssd_render u_render (
        .i_code          (r_store[r_scan_pos]),
        .i_pos           (r_scan_pos),
        .o_segment_drive (seg_drive),
        .o_digit_select  (dig_select)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_cmd  <= i_in.command;
            r_s1_pos  <= i_in.digit_position;
            r_s1_code <= i_in.glyph_code;
        end
    end

    // The store and scan position change only as a request leaves the
    // request register, so a write is seen by the very next tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_store[i] <= BLANK_CODE;
            end
            r_scan_pos <= '0;
        end else if (s1_adv) begin
            if (s1_is_write) begin
                r_store[r_s1_pos] <= r_s1_code;
            end else begin
                r_scan_pos <= n_scan_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && !s1_is_write) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && !s1_is_write) begin
            r_seg <= seg_drive;
            r_sel <= dig_select;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.segment_drive = r_seg;
    assign o_out.digit_select  = r_sel;

    // The scan never leaves the populated digits.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_scan_pos} < (POS_W+1)'(DIGIT_COUNT))
        else $error("scan position beyond digit count");

    // Exactly one digit enable is low on every result.
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($countones(~r_sel) == 1))
        else $error("digit select not one-hot low");

    // A tick leaving the request register yields a result next cycle.
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && !s1_is_write) |=> r_out_valid)
        else $error("tick lost its result");

    // A write never moves the scan.
    a_write_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s1_is_write) |=> $stable(r_scan_pos))
        else $error("write moved the scan position");

    // A held result is not overwritten by a new tick.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !(s1_adv && !s1_is_write))
        else $error("result register overrun");

endmodule
